// ----- rtl/datp_pkg.sv -----
// Shared types, codes and helpers for the device attribute TLV parser.
// No dependencies; the parser, the result buffer and the top level import this package.
package datp_pkg;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ATTR    = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_DATA  = 1'b1;

    // Attribute type codes
    localparam logic [7:0] TYPE_VSTR  = 8'd1;
    localparam logic [7:0] TYPE_UINT  = 8'd2;
    localparam logic [7:0] TYPE_INT   = 8'd3;
    localparam logic [7:0] TYPE_FLOAT = 8'd4;
    localparam logic [7:0] TYPE_OCTET = 8'd5;
    localparam logic [7:0] TYPE_BITS  = 8'd6;
    localparam logic [7:0] TYPE_TIME  = 8'd7;
    localparam logic [7:0] TYPE_UNI   = 8'd8;
    localparam logic [7:0] TYPE_LIST  = 8'd254;
    localparam logic [7:0] TYPE_XLIST = 8'd255;

    // Attribute classes
    localparam logic [3:0] CLS_VSTR  = 4'd0;
    localparam logic [3:0] CLS_UINT  = 4'd1;
    localparam logic [3:0] CLS_INT   = 4'd2;
    localparam logic [3:0] CLS_FLOAT = 4'd3;
    localparam logic [3:0] CLS_OCTET = 4'd4;
    localparam logic [3:0] CLS_BITS  = 4'd5;
    localparam logic [3:0] CLS_TIME  = 4'd6;
    localparam logic [3:0] CLS_UNI   = 4'd7;
    localparam logic [3:0] CLS_LIST  = 4'd8;
    localparam logic [3:0] CLS_XLIST = 4'd9;

    // Payload lengths with a defined value decoding
    localparam logic [7:0] LEN_1 = 8'd1;
    localparam logic [7:0] LEN_2 = 8'd2;
    localparam logic [7:0] LEN_4 = 8'd4;
    localparam logic [7:0] LEN_6 = 8'd6;
    localparam logic [7:0] LEN_8 = 8'd8;

    // Most results one input item can cause
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         set_index;
        logic [7:0]         variation_out;
        logic [3:0]         attr_class;
        logic [7:0]         payload_out;
        logic [31:0]        unsigned_value;
        logic signed [31:0] signed_value;
        logic [63:0]        float_bits;
        logic               float_is_double;
        logic [47:0]        time_value;
        logic               status;
        logic               last;
    } result_t;

    // Results caused by one accepted item, in delivery order
    typedef struct packed {
        logic [1:0]                       count;
        result_t [MAX_RESULTS-1:0]        res;
    } bundle_t;

    function automatic logic [3:0] class_of(input logic [7:0] t);
        logic [3:0] c;
        case (t)
            TYPE_VSTR:  c = CLS_VSTR;
            TYPE_UINT:  c = CLS_UINT;
            TYPE_INT:   c = CLS_INT;
            TYPE_FLOAT: c = CLS_FLOAT;
            TYPE_OCTET: c = CLS_OCTET;
            TYPE_BITS:  c = CLS_BITS;
            TYPE_TIME:  c = CLS_TIME;
            TYPE_UNI:   c = CLS_UNI;
            TYPE_LIST:  c = CLS_LIST;
            TYPE_XLIST: c = CLS_XLIST;
            default:    c = CLS_OCTET;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/datp_if.sv -----
// Valid/ready channel interfaces for the TLV parser input and result items.
// Does not import datp_pkg; payload is plain logic.
interface datp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [15:0] range_start;
    logic [15:0] range_stop;
    logic [7:0]  variation;

    modport source (output valid, cmd, data_byte, range_start, range_stop, variation,
                    input ready);
    modport sink   (input valid, cmd, data_byte, range_start, range_stop, variation,
                    output ready);
endinterface

interface datp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         set_index;
    logic [7:0]         variation_out;
    logic [3:0]         attr_class;
    logic [7:0]         payload_out;
    logic [31:0]        unsigned_value;
    logic signed [31:0] signed_value;
    logic [63:0]        float_bits;
    logic               float_is_double;
    logic [47:0]        time_value;
    logic               status;
    logic               last;

    modport source (output valid, kind, set_index, variation_out, attr_class, payload_out,
                    unsigned_value, signed_value, float_bits, float_is_double,
                    time_value, status, last,
                    input ready);
    modport sink   (input valid, kind, set_index, variation_out, attr_class, payload_out,
                    unsigned_value, signed_value, float_bits, float_is_double,
                    time_value, status, last,
                    output ready);
endinterface

// ----- rtl/datp_parser.sv -----
// Parser state registers and the one-step TLV decode that forms a result bundle.
// Depends on datp_pkg and datp_in_if.
module datp_parser
    import datp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    datp_in_if.sink       din,
    input  logic          can_load,
    output logic          load,
    output bundle_t       bundle
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_PAY  = 2'd3;

    logic [1:0]  phase_reg,     phase_next;
    logic [7:0]  type_reg,      type_next;
    logic [7:0]  len_reg,       len_next;
    logic [7:0]  seen_reg,      seen_next;
    logic [63:0] acc_reg,       acc_next;
    logic [16:0] left_reg,      left_next;
    logic [7:0]  set_reg,       set_next;
    logic [7:0]  var_reg,       var_next;

    logic        do_finish;
    logic [7:0]  len_fin;
    logic [63:0] acc_fin;
    logic [63:0] acc_upd;
    logic [7:0]  seen_inc;
    logic [16:0] left_dec;
    logic [7:0]  var_cur;
    logic [1:0]  cnt;
    result_t [MAX_RESULTS-1:0] res;

    function automatic result_t attr_result(input logic [7:0] set, input logic [7:0] vr,
                                            input logic [7:0] t, input logic [7:0] len,
                                            input logic [63:0] a);
        result_t r;
        r = '0;
        r.kind          = KIND_ATTR;
        r.set_index     = set;
        r.variation_out = vr;
        r.attr_class    = class_of(t);
        case (t)
            TYPE_UINT:
            begin
                if (len == LEN_1)      r.unsigned_value = {24'd0, a[7:0]};
                else if (len == LEN_2) r.unsigned_value = {16'd0, a[15:0]};
                else if (len == LEN_4) r.unsigned_value = a[31:0];
            end
            TYPE_INT:
            begin
                if (len == LEN_1)      r.signed_value = {{24{a[7]}}, a[7:0]};
                else if (len == LEN_2) r.signed_value = {{16{a[15]}}, a[15:0]};
                else if (len == LEN_4) r.signed_value = a[31:0];
            end
            TYPE_FLOAT:
            begin
                if (len == LEN_4)
                begin
                    r.float_bits = {32'd0, a[31:0]};
                end
                else if (len == LEN_8)
                begin
                    r.float_bits      = a;
                    r.float_is_double = 1'b1;
                end
            end
            TYPE_TIME:
            begin
                if (len == LEN_6) r.time_value = a[47:0];
            end
            default:
            begin
                r.kind = KIND_ATTR;
            end
        endcase
        return r;
    endfunction

    function automatic result_t status_result(input logic [7:0] vr, input logic st);
        result_t r;
        r = '0;
        r.kind          = KIND_STATUS;
        r.variation_out = vr;
        r.status        = st;
        return r;
    endfunction

    assign din.ready = can_load;
    assign load      = din.valid && can_load;

    // Only the first eight payload bytes land in the accumulator
    assign acc_upd  = (seen_reg < LEN_8)
                      ? (acc_reg | ({56'd0, din.data_byte} << {seen_reg[2:0], 3'b000}))
                      : acc_reg;
    assign seen_inc = seen_reg + 8'd1;
    assign left_dec = (left_reg == 17'd0) ? 17'd0 : left_reg - 17'd1;
    assign var_cur  = (din.cmd == CMD_START) ? din.variation : var_reg;

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        set_next   = set_reg;
        var_next   = var_reg;
        do_finish  = 1'b0;
        len_fin    = len_reg;
        acc_fin    = acc_reg;
        cnt        = 2'd0;
        res        = '0;

        if (load)
        begin
            case (din.cmd)
                CMD_START:
                begin
                    var_next  = din.variation;
                    set_next  = din.range_start[7:0];
                    left_next = (din.range_stop >= din.range_start)
                                ? ({1'b0, din.range_stop} - {1'b0, din.range_start} + 17'd1)
                                : 17'd0;
                    type_next = 8'd0;
                    len_next  = 8'd0;
                    seen_next = 8'd0;
                    acc_next  = 64'd0;
                    if (din.range_stop < din.range_start)
                    begin
                        phase_next = PH_IDLE;
                        res[cnt]   = status_result(din.variation, STATUS_OK);
                        cnt        = cnt + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                CMD_DATA:
                begin
                    case (phase_reg)
                        PH_TYPE:
                        begin
                            type_next  = din.data_byte;
                            phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            len_next  = din.data_byte;
                            seen_next = 8'd0;
                            acc_next  = 64'd0;
                            if (din.data_byte == 8'd0)
                            begin
                                do_finish = 1'b1;
                                len_fin   = 8'd0;
                                acc_fin   = 64'd0;
                            end
                            else
                            begin
                                phase_next = PH_PAY;
                            end
                        end
                        PH_PAY:
                        begin
                            res[cnt].kind          = KIND_PAYLOAD;
                            res[cnt].set_index     = set_reg;
                            res[cnt].variation_out = var_reg;
                            res[cnt].attr_class    = class_of(type_reg);
                            res[cnt].payload_out   = din.data_byte;
                            cnt       = cnt + 2'd1;
                            acc_next  = acc_upd;
                            seen_next = seen_inc;
                            if (seen_inc >= len_reg)
                            begin
                                do_finish = 1'b1;
                                acc_fin   = acc_upd;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                CMD_END:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        phase_next = PH_IDLE;
                        left_next  = 17'd0;
                        res[cnt]   = status_result(var_cur, STATUS_NO_DATA);
                        cnt        = cnt + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Close the attribute; the last one of the header also reports status
            if (do_finish)
            begin
                res[cnt]  = attr_result(set_reg, var_reg, type_reg, len_fin, acc_fin);
                cnt       = cnt + 2'd1;
                set_next  = set_reg + 8'd1;
                left_next = left_dec;
                if (left_dec == 17'd0)
                begin
                    phase_next = PH_IDLE;
                    res[cnt]   = status_result(var_reg, STATUS_OK);
                    cnt        = cnt + 2'd1;
                end
                else
                begin
                    phase_next = PH_TYPE;
                end
            end

            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res[i].last = (cnt != 2'd0) && (i == int'(cnt) - 1);
            end
        end

        bundle.count = cnt;
        bundle.res   = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            type_reg  <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            acc_reg   <= 64'd0;
            left_reg  <= 17'd0;
            set_reg   <= 8'd0;
            var_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            set_reg   <= set_next;
            var_reg   <= var_next;
        end
    end

endmodule

// ----- rtl/datp_result_buf.sv -----
// Result register that holds one item's bundle and hands out one result per cycle while dout.ready is high.
// Depends on datp_pkg and datp_out_if.
module datp_result_buf
    import datp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  bundle_t       bundle,
    output logic          can_load,
    datp_out_if.source    dout
);

    logic [1:0]                count_reg;
    result_t [MAX_RESULTS-1:0] slot_reg;
    logic                      take;
    result_t                   head;

    assign take     = dout.valid && dout.ready;
    // Refill when empty or when the final held result leaves this cycle
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && dout.ready);
    assign head     = slot_reg[0];

    assign dout.valid           = (count_reg != 2'd0);
    assign dout.kind            = head.kind;
    assign dout.set_index       = head.set_index;
    assign dout.variation_out   = head.variation_out;
    assign dout.attr_class      = head.attr_class;
    assign dout.payload_out     = head.payload_out;
    assign dout.unsigned_value  = head.unsigned_value;
    assign dout.signed_value    = head.signed_value;
    assign dout.float_bits      = head.float_bits;
    assign dout.float_is_double = head.float_is_double;
    assign dout.time_value      = head.time_value;
    assign dout.status          = head.status;
    assign dout.last            = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= bundle.count;
        end
        else if (take)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle.res;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

endmodule

// ----- rtl/device_attribute_tlv_parser_core.sv -----
// Top level of the device attribute TLV parser: parser stage plus result register.
// Depends on datp_pkg, datp_if.sv, datp_parser and datp_result_buf.
//
//   Channel  Dir  Handshake      Item
//   din      in   valid/ready    cmd, data_byte, range_start, range_stop, variation
//   dout     out  valid/ready    one result: kind, set_index, ... , status, last
//
// Flow: an accepted item is decoded in the cycle it is taken; its results (0 to 3)
// sit in the result register and leave one per cycle while dout.ready is high. A
// new item is taken every cycle while each causes at most one result and dout.ready
// is high; an item with more results holds din until its last result is leaving.
// Reset: rst_n clears the parser state to idle and empties the result register.
// Stalls: a low dout.ready holds the current result and blocks din once the
// register holds more than the result being taken.
module device_attribute_tlv_parser_core
    import datp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    datp_in_if.sink    din,
    datp_out_if.source dout
);

    bundle_t bundle;
    logic    load;
    logic    can_load;

    // Decode the item against the header state and form its result bundle
    datp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .can_load (can_load),
        .load     (load),
        .bundle   (bundle)
    );

    // Hold the bundle and advance it to the output one result at a time
    datp_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .bundle   (bundle),
        .can_load (can_load),
        .dout     (dout)
    );

endmodule
